/* rtl/core/hgvc_pkg.sv */
// ----------------------------------------------------------------------------
// hgvc_pkg
// Shared types, register indexes, reset values and CORDIC constants for the
// holonomic go-to-goal velocity controller.
// ----------------------------------------------------------------------------
package hgvc_pkg;

  // Request and result payloads
  typedef struct packed {
    logic               plan_valid;
    logic               new_plan;
    logic signed [23:0] goal_x;
    logic signed [23:0] goal_y;
    logic signed [15:0] goal_quat_z;
    logic signed [15:0] goal_quat_w;
  } in_req_t;

  typedef struct packed {
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic               at_goal;
  } out_res_t;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 23;

  localparam logic [CfgIdxW-1:0] CFG_LINEAR_GAIN        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ANGULAR_GAIN       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_POSITION_TOLERANCE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HEADING_TOLERANCE  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LINEAR_LIMIT       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ANGULAR_LIMIT      = 3'd5;

  localparam logic [15:0] RST_LINEAR_GAIN        = 16'd2048;
  localparam logic [15:0] RST_ANGULAR_GAIN       = 16'd2048;
  localparam logic [22:0] RST_POSITION_TOLERANCE = 23'd1311;
  localparam logic [14:0] RST_HEADING_TOLERANCE  = 15'd410;
  localparam logic [22:0] RST_LINEAR_LIMIT       = 23'd36045;
  localparam logic [14:0] RST_ANGULAR_LIMIT      = 15'd12288;

  // Shared multiplier operand / product widths
  localparam int unsigned MulW  = 25;
  localparam int unsigned ProdW = 2 * MulW;

  // CORDIC
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned AtanLen      = 24;
  localparam int unsigned CordicIters  = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;
  localparam int unsigned IterW        = $clog2(AtanLen);
  localparam int unsigned CordW        = 44;  // x,y scaled by 2^16 plus growth
  localparam int unsigned AngW         = 34;  // Q2.30 accumulator with headroom

  localparam logic signed [AngW-1:0] PI_HALF_Q30 = 34'sd1686629713;

  // Truncated arctan(2^-i) in Q2.30
  function automatic logic signed [AngW-1:0] atan_q30(input logic [IterW-1:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      5'd0:    v = 34'sd843314856;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043836;
      5'd3:    v = 34'sd133525158;
      5'd4:    v = 34'sd67021686;
      5'd5:    v = 34'sd33543515;
      5'd6:    v = 34'sd16775850;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194282;
      5'd9:    v = 34'sd2097149;
      5'd10:   v = 34'sd1048575;
      5'd11:   v = 34'sd524287;
      5'd12:   v = 34'sd262143;
      5'd13:   v = 34'sd131071;
      5'd14:   v = 34'sd65535;
      5'd15:   v = 34'sd32767;
      5'd16:   v = 34'sd16383;
      5'd17:   v = 34'sd8191;
      5'd18:   v = 34'sd4095;
      5'd19:   v = 34'sd2047;
      5'd20:   v = 34'sd1023;
      5'd21:   v = 34'sd511;
      5'd22:   v = 34'sd255;
      5'd23:   v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/hgvc_mul.sv */
// ----------------------------------------------------------------------------
// hgvc_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module hgvc_mul (
  input  logic                                clk_i,
  input  logic signed [hgvc_pkg::MulW-1:0]    a_i,
  input  logic signed [hgvc_pkg::MulW-1:0]    b_i,
  output logic signed [hgvc_pkg::ProdW-1:0]   p_o
);

  logic signed [hgvc_pkg::ProdW-1:0] p_d, p_q;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

/* rtl/core/hgvc_cordic.sv */
// ----------------------------------------------------------------------------
// hgvc_cordic
// Iterative vectoring CORDIC: atan2(y, x) in Q4.12 radians, one
// micro-rotation per cycle on a single shift/add datapath.
// ----------------------------------------------------------------------------
module hgvc_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [23:0] y_i,
  input  logic signed [23:0] x_i,
  output logic               done_o,
  output logic signed [15:0] angle_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_ITER,
    ST_RND
  } cord_state_e;

  cord_state_e state_q, state_d;
  logic [hgvc_pkg::IterW-1:0] iter_q, iter_d;
  logic done_q, done_d;

  logic signed [hgvc_pkg::CordW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [hgvc_pkg::AngW-1:0]  z_q, z_d;
  logic signed [15:0]                angle_q, angle_d;

  logic signed [hgvc_pkg::CordW-1:0] dx, dy;
  logic signed [hgvc_pkg::AngW-1:0]  z_rnd;

  assign dx    = cy_q >>> iter_q;
  assign dy    = cx_q >>> iter_q;
  assign z_rnd = (z_q + hgvc_pkg::AngW'(131072)) >>> 18;

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    done_d  = 1'b0;
    cx_d    = cx_q;
    cy_d    = cy_q;
    z_d     = z_q;
    angle_d = angle_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cx_d    = {{4{x_i[23]}}, x_i, 16'b0};
          cy_d    = {{4{y_i[23]}}, y_i, 16'b0};
          z_d     = '0;
          iter_d  = '0;
          state_d = ST_PRE;
        end
      end
      ST_PRE: begin
        if (cx_q == '0 && cy_q == '0) begin
          // both operands zero: z is still zero, so rounding gives angle zero
          state_d = ST_RND;
        end else begin
          if (cx_q < 0) begin
            if (cy_q >= 0) begin
              cx_d = cy_q;
              cy_d = -cx_q;
              z_d  = hgvc_pkg::PI_HALF_Q30;
            end else begin
              cx_d = -cy_q;
              cy_d = cx_q;
              z_d  = -hgvc_pkg::PI_HALF_Q30;
            end
          end
          state_d = ST_ITER;
        end
      end
      ST_ITER: begin
        if (cy_q >= 0) begin
          cx_d = cx_q + dx;
          cy_d = cy_q - dy;
          z_d  = z_q + hgvc_pkg::atan_q30(iter_q);
        end else begin
          cx_d = cx_q - dx;
          cy_d = cy_q + dy;
          z_d  = z_q - hgvc_pkg::atan_q30(iter_q);
        end
        if (iter_q == hgvc_pkg::IterW'(hgvc_pkg::CordicIters - 1)) begin
          state_d = ST_RND;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      ST_RND: begin
        angle_d = z_rnd[15:0];
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    z_q     <= z_d;
    angle_q <= angle_d;
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

/* rtl/core/holonomic_goal_velocity_controller.sv */
// ----------------------------------------------------------------------------
// holonomic_goal_velocity_controller
// Proportional go-to-goal controller for a holonomic base.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_req_i): one request per
//   control tick carrying the goal pose in robot frame, a plan-valid flag and
//   a new-plan flag. Output channel (out_valid_o / out_ready_i / out_res_o):
//   one result per request with vx, vy, yaw rate and the sticky reached flag.
//   Sequence: a valid-plan request forms the squared distance (SQX, SQY,
//   SQT), then starts the CORDIC in the compare state (CMP) with the linear
//   products overlapped (VX, VY), then waits for the angle and forms the yaw
//   product (CWAIT, W) before loading the output register (DONE). An
//   invalid-plan request goes straight to the output load with zeros. The
//   CORDIC loop sets the rate; one request is in flight at a time.
//   The result sits in an output register, so the next request is taken as
//   soon as the sequencer is back to idle even if the result is not yet
//   taken; if the receiver stalls long enough, the finished request waits in
//   its last state until the output register frees up.
//   Reset clears the reached flag and loads the default registers, written
//   through cfg_we_i/cfg_index_i/cfg_data_i; the user writes them only while
//   idle, which the block does not enforce; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module holonomic_goal_velocity_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  hgvc_pkg::in_req_t                    in_req_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output hgvc_pkg::out_res_t                   out_res_o,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [hgvc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [hgvc_pkg::CfgDataW-1:0]        cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,    // gx*gx
    ST_SQY,    // gy*gy, latch gx^2
    ST_SQT,    // tol*tol, accumulate gy^2
    ST_CMP,    // near test, start CORDIC, gain*gx
    ST_VX,     // round/clamp vx, gain*gy
    ST_VY,     // round/clamp vy
    ST_CWAIT,  // wait for angle, gain*heading
    ST_W,      // round/clamp yaw rate
    ST_DONE    // load output register
  } ctl_state_e;

  // ---------------- configuration registers ----------------
  logic [15:0] lin_gain_q, ang_gain_q;
  logic [22:0] pos_tol_q, lin_lim_q;
  logic [14:0] head_tol_q, ang_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q <= hgvc_pkg::RST_LINEAR_GAIN;
      ang_gain_q <= hgvc_pkg::RST_ANGULAR_GAIN;
      pos_tol_q  <= hgvc_pkg::RST_POSITION_TOLERANCE;
      head_tol_q <= hgvc_pkg::RST_HEADING_TOLERANCE;
      lin_lim_q  <= hgvc_pkg::RST_LINEAR_LIMIT;
      ang_lim_q  <= hgvc_pkg::RST_ANGULAR_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hgvc_pkg::CFG_LINEAR_GAIN:        lin_gain_q <= cfg_data_i[15:0];
        hgvc_pkg::CFG_ANGULAR_GAIN:       ang_gain_q <= cfg_data_i[15:0];
        hgvc_pkg::CFG_POSITION_TOLERANCE: pos_tol_q  <= cfg_data_i[22:0];
        hgvc_pkg::CFG_HEADING_TOLERANCE:  head_tol_q <= cfg_data_i[14:0];
        hgvc_pkg::CFG_LINEAR_LIMIT:       lin_lim_q  <= cfg_data_i[22:0];
        hgvc_pkg::CFG_ANGULAR_LIMIT:      ang_lim_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // ---------------- round (+2^11, floor >> 12) and symmetric clamp ----------------
  function automatic logic signed [23:0] round_clamp(
    input logic signed [hgvc_pkg::ProdW-1:0] p,
    input logic [22:0]                       lim
  );
    logic signed [hgvc_pkg::ProdW-1:0] r;
    logic signed [hgvc_pkg::ProdW-1:0] l;
    logic signed [23:0]                res;
    r = (p + hgvc_pkg::ProdW'(2048)) >>> 12;
    l = {{(hgvc_pkg::ProdW-23){1'b0}}, lim};
    if (r > l) begin
      res = l[23:0];
    end else if (r < -l) begin
      res = 24'(-l);
    end else begin
      res = r[23:0];
    end
    return res;
  endfunction

  // ---------------- sequencer state ----------------
  ctl_state_e state_q, state_d;
  logic       reached_q, reached_d;
  logic       out_valid_q, out_valid_d;

  // item payload and intermediate results
  hgvc_pkg::in_req_t  req_q, req_d;
  logic [47:0]        acc_q, acc_d;        // gx^2 + gy^2
  logic               near_q, near_d;
  logic signed [23:0] vx_q, vx_d, vy_q, vy_d;
  logic signed [15:0] wz_q, wz_d;
  hgvc_pkg::out_res_t res_q, res_d;

  // shared multiplier
  logic signed [hgvc_pkg::MulW-1:0]  mul_a, mul_b;
  logic signed [hgvc_pkg::ProdW-1:0] prod;

  hgvc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // CORDIC unit
  logic               cord_start;
  logic signed [23:0] cord_y, cord_x;
  logic               cord_done;
  logic signed [15:0] cord_angle;

  hgvc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .y_i     (cord_y),
    .x_i     (cord_x),
    .done_o  (cord_done),
    .angle_o (cord_angle)
  );

  logic               near_now;
  logic signed [15:0] heading;
  logic [15:0]        head_mag;

  assign near_now = acc_q < prod[47:0];
  // goal yaw is twice the half-angle from the quaternion
  assign heading  = near_q ? (cord_angle <<< 1) : cord_angle;
  assign head_mag = heading[15] ? 16'(-heading) : 16'(heading);

  // operands: near goal aligns to goal yaw, otherwise heads for the goal
  assign cord_start = (state_q == ST_CMP);
  assign cord_y = near_now ? {{8{req_q.goal_quat_z[15]}}, req_q.goal_quat_z} : req_q.goal_y;
  assign cord_x = near_now ? {{8{req_q.goal_quat_w[15]}}, req_q.goal_quat_w} : req_q.goal_x;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQX: begin
        mul_a = {req_q.goal_x[23], req_q.goal_x};
        mul_b = {req_q.goal_x[23], req_q.goal_x};
      end
      ST_SQY: begin
        mul_a = {req_q.goal_y[23], req_q.goal_y};
        mul_b = {req_q.goal_y[23], req_q.goal_y};
      end
      ST_SQT: begin
        mul_a = {2'b00, pos_tol_q};
        mul_b = {2'b00, pos_tol_q};
      end
      ST_CMP: begin
        mul_a = {9'b0, lin_gain_q};
        mul_b = {req_q.goal_x[23], req_q.goal_x};
      end
      ST_VX: begin
        mul_a = {9'b0, lin_gain_q};
        mul_b = {req_q.goal_y[23], req_q.goal_y};
      end
      ST_CWAIT: begin
        mul_a = {9'b0, ang_gain_q};
        mul_b = {{9{heading[15]}}, heading};
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    reached_d   = reached_q;
    out_valid_d = out_valid_q;
    req_d       = req_q;
    acc_d       = acc_q;
    near_d      = near_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    wz_d        = wz_q;
    res_d       = res_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          if (in_req_i.new_plan) begin
            reached_d = 1'b0;
          end
          if (in_req_i.plan_valid) begin
            state_d = ST_SQX;
          end else begin
            vx_d    = '0;
            vy_d    = '0;
            wz_d    = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_SQX: state_d = ST_SQY;
      ST_SQY: begin
        acc_d   = prod[47:0];
        state_d = ST_SQT;
      end
      ST_SQT: begin
        acc_d   = acc_q + prod[47:0];
        state_d = ST_CMP;
      end
      ST_CMP: begin
        near_d  = near_now;
        state_d = ST_VX;
      end
      ST_VX: begin
        vx_d    = round_clamp(prod, lin_lim_q);
        state_d = ST_VY;
      end
      ST_VY: begin
        vy_d    = round_clamp(prod, lin_lim_q);
        state_d = ST_CWAIT;
      end
      ST_CWAIT: begin
        if (cord_done) begin
          if (near_q && (head_mag < {1'b0, head_tol_q})) begin
            reached_d = 1'b1;
          end
          state_d = ST_W;
        end
      end
      ST_W: begin
        wz_d    = 16'(round_clamp(prod, {8'b0, ang_lim_q}));
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          res_d.vel_x    = vx_q;
          res_d.vel_y    = vy_q;
          res_d.yaw_rate = wz_q;
          // a stop request reports the flag as clear but keeps it unless new_plan is set
          res_d.at_goal  = req_q.plan_valid & reached_q;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      reached_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      reached_q   <= reached_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    acc_q  <= acc_d;
    near_q <= near_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    wz_q   <= wz_d;
    res_q  <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule
